@@ design/sgtc_pkg.sv @@
// Shared constants, types and codes for the sensor grid tristate classifier.
package sgtc_pkg;

   localparam int SQUARES      = 64;
   localparam int SAMPLE_WIDTH = 10;
   localparam int ADDR_W       = (SQUARES > 1) ? $clog2(SQUARES) : 1;
   localparam int SENS_W       = 10;
   localparam int CMP_W        = ((SAMPLE_WIDTH > SENS_W) ? SAMPLE_WIDTH : SENS_W) + 1;

   typedef logic [5:0]              square_type;
   typedef logic [9:0]              sample_in_type;
   typedef logic [SENS_W-1:0]       sens_type;
   typedef logic [SAMPLE_WIDTH-1:0] base_type;
   typedef logic [ADDR_W-1:0]       addr_type;
   typedef logic [CMP_W-1:0]        cmp_type;

   typedef enum logic {
      KIND_CALIBRATE = 1'b0,
      KIND_MEASURE   = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CLASS_EMPTY = 2'd0,
      CLASS_BLACK = 2'd1,
      CLASS_WHITE = 2'd2
   } class_type;

   typedef enum logic [1:0] {
      EV_PLACED   = 2'd0,
      EV_REMOVED  = 2'd1,
      EV_REPLACED = 2'd2
   } event_kind_type;

endpackage

@@ design/sgtc_req_if.sv @@
// Input channel: one sample beat per square.
interface sgtc_req_if;
   logic                   valid;
   logic                   ready;
   sgtc_pkg::kind_type     kind;
   sgtc_pkg::square_type   square;
   sgtc_pkg::sample_in_type sample;

   modport source (output valid, kind, square, sample, input ready);
   modport sink   (input valid, kind, square, sample, output ready);
endinterface

@@ design/sgtc_rsp_if.sv @@
// Result channel: one class-change event per beat.
interface sgtc_rsp_if;
   logic                         valid;
   logic                         ready;
   sgtc_pkg::square_type         event_square;
   sgtc_pkg::class_type          old_class;
   sgtc_pkg::class_type          new_class;
   sgtc_pkg::event_kind_type     event_kind;

   modport source (output valid, event_square, old_class, new_class, event_kind,
                   input ready);
   modport sink   (input valid, event_square, old_class, new_class, event_kind,
                   output ready);
endinterface

@@ design/sgtc_csr_if.sv @@
// Configuration write channel: sensitivity register data.
interface sgtc_csr_if;
   logic               valid;
   logic               ready;
   sgtc_pkg::sens_type data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ design/sensor_grid_tristate_classifier.sv @@
// Top level of the sensor grid tristate classifier: baseline and class memories.
//
// Usage:
//   req  - sample beats. kind calibrate stores the sample as the square's
//          baseline; kind measure classifies it as black, white or empty
//          against baseline -/+ sensitivity. Squares beyond the grid are dropped.
//   rsp  - one event beat (square, old class, new class, kind) for each measure
//          beat that changes the square's stored class; nothing otherwise.
//   csr  - writes the sensitivity register; always ready.
// Pipeline: an accepted req beat enters stage 1, and its event then enters the
//   rsp register. Throughput: one req beat per cycle while req.ready is high.
//   Each beat reads both memories at stage 0 and writes back at stage 1; a write
//   by the beat directly ahead to the same square is forwarded around the read.
// Reset: a clearing pass writes zero baselines and empty classes to every
//   square, one square per cycle; req.ready stays low during the pass. csr
//   writes are taken throughout.
// Stall: the rsp register holds an event while the receiver is stalled. Beats
//   that emit nothing keep flowing; a beat that needs the held register waits
//   at stage 1 and req.ready drops until the register frees.
module sensor_grid_tristate_classifier (
   input  logic                clock,
   input  logic                reset,
   sgtc_req_if.sink            req,
   sgtc_rsp_if.source          rsp,
   sgtc_csr_if.sink            csr
);
   import sgtc_pkg::*;

   // memories
   base_type  base_mem [SQUARES];
   class_type cls_mem  [SQUARES];

   // registers
   sens_type       sens_ff;
   logic           clr_active_ff;
   addr_type       clr_cnt_ff;
   base_type       rd_base_ff;
   class_type      rd_cls_ff;
   logic           s1_valid_ff;
   kind_type       s1_kind_ff;
   logic           s1_inrange_ff;
   addr_type       s1_addr_ff;
   square_type     s1_square_ff;
   base_type       s1_smp_ff;
   logic           byp_base_ff;
   base_type       byp_base_data_ff;
   logic           byp_cls_ff;
   class_type      byp_cls_data_ff;
   logic           rsp_valid_ff;
   square_type     rsp_square_ff;
   class_type      rsp_old_ff;
   class_type      rsp_new_ff;
   event_kind_type rsp_kind_ff;

   // next values
   logic           clr_active_in;
   addr_type       clr_cnt_in;
   logic           s1_valid_in;
   logic           byp_base_in;
   logic           byp_cls_in;
   logic           rsp_valid_in;

   // stage 1 logic
   base_type       cur_base;
   class_type      cur_cls;
   class_type      new_cls;
   event_kind_type ev_kind;
   logic           is_black;
   logic           is_white;
   logic           ev_hit;
   logic           out_free;
   logic           stall;
   logic           s1_go;
   logic           accept;
   addr_type       req_addr;
   addr_type       rd_addr;
   logic           base_wr_item;
   logic           cls_wr_item;
   logic           base_we;
   logic           cls_we;
   addr_type       wr_addr;
   base_type       base_wdata;
   class_type      cls_wdata;

   // forward the write of the beat directly ahead past the read latency
   assign cur_base = byp_base_ff ? byp_base_data_ff : rd_base_ff;
   assign cur_cls  = byp_cls_ff  ? byp_cls_data_ff  : rd_cls_ff;

   // exact compare in a widened unsigned domain: no wrap on either side
   assign is_black = (CMP_W'(s1_smp_ff) + CMP_W'(sens_ff)) < CMP_W'(cur_base);
   assign is_white = CMP_W'(s1_smp_ff) > (CMP_W'(cur_base) + CMP_W'(sens_ff));

   always_comb begin
      if (is_black) begin
         new_cls = CLASS_BLACK;
      end else if (is_white) begin
         new_cls = CLASS_WHITE;
      end else begin
         new_cls = CLASS_EMPTY;
      end
      if (cur_cls == CLASS_EMPTY) begin
         ev_kind = EV_PLACED;
      end else if (new_cls == CLASS_EMPTY) begin
         ev_kind = EV_REMOVED;
      end else begin
         ev_kind = EV_REPLACED;
      end
   end

   assign ev_hit   = s1_valid_ff && s1_inrange_ff && (s1_kind_ff == KIND_MEASURE)
                     && (new_cls != cur_cls);
   assign out_free = !rsp_valid_ff || rsp.ready;
   // hold stage 1 only when its event finds the rsp register occupied
   assign stall    = ev_hit && !out_free;
   assign s1_go    = s1_valid_ff && !stall;

   assign req.ready = !clr_active_ff && !stall;
   assign accept    = req.valid && req.ready;
   assign req_addr  = ADDR_W'(req.square);
   // re-read the held square while stalled so the data stays current
   assign rd_addr   = stall ? s1_addr_ff : req_addr;

   assign base_wr_item = s1_go && s1_inrange_ff && (s1_kind_ff == KIND_CALIBRATE);
   assign cls_wr_item  = s1_go && ev_hit;

   assign base_we    = clr_active_ff || base_wr_item;
   assign cls_we     = clr_active_ff || cls_wr_item;
   assign wr_addr    = clr_active_ff ? clr_cnt_ff : s1_addr_ff;
   assign base_wdata = clr_active_ff ? '0 : s1_smp_ff;
   assign cls_wdata  = clr_active_ff ? CLASS_EMPTY : new_cls;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_cnt_in    = clr_cnt_ff;
      if (clr_active_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == ADDR_W'(SQUARES - 1)) begin
            clr_active_in = 1'b0;
         end
      end
      s1_valid_in  = stall ? 1'b1 : accept;
      byp_base_in  = !stall && base_wr_item && (s1_addr_ff == req_addr);
      byp_cls_in   = !stall && cls_wr_item  && (s1_addr_ff == req_addr);
      rsp_valid_in = out_free ? (s1_go && ev_hit) : rsp_valid_ff;
   end

   // memory ports: one write, one registered read each
   always_ff @(posedge clock) begin
      if (base_we) begin
         base_mem[wr_addr] <= base_wdata;
      end
      if (cls_we) begin
         cls_mem[wr_addr] <= cls_wdata;
      end
      rd_base_ff <= base_mem[rd_addr];
      rd_cls_ff  <= cls_mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff       <= '0;
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         byp_base_ff   <= 1'b0;
         byp_cls_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr.valid && csr.ready) begin
            sens_ff <= csr.data;
         end
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         byp_base_ff   <= byp_base_in;
         byp_cls_ff    <= byp_cls_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_kind_ff    <= req.kind;
         s1_square_ff  <= req.square;
         s1_addr_ff    <= req_addr;
         s1_inrange_ff <= (32'(req.square) < SQUARES);
         s1_smp_ff     <= SAMPLE_WIDTH'(req.sample);
      end
      byp_base_data_ff <= s1_smp_ff;
      byp_cls_data_ff  <= new_cls;
      if (out_free && s1_go && ev_hit) begin
         rsp_square_ff <= s1_square_ff;
         rsp_old_ff    <= cur_cls;
         rsp_new_ff    <= new_cls;
         rsp_kind_ff   <= ev_kind;
      end
   end

   assign csr.ready        = 1'b1;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.event_square = rsp_square_ff;
   assign rsp.old_class    = rsp_old_ff;
   assign rsp.new_class    = rsp_new_ff;
   assign rsp.event_kind   = rsp_kind_ff;

   // no sample beat enters while the clearing pass runs
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !req.ready)
      else $error("req beat taken during clearing pass");

   // an event always reports a real change
   a_event_changes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_old_ff != rsp_new_ff))
      else $error("event with unchanged class");

   // every class write-back is followed by a waiting event
   a_cls_write_emits: assert property (@(posedge clock) disable iff (reset)
      cls_wr_item |=> rsp_valid_ff)
      else $error("class written without event");

   // a beat writes at most one memory
   a_single_write: assert property (@(posedge clock) disable iff (reset)
      !(base_wr_item && cls_wr_item))
      else $error("beat wrote both memories");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the sensor grid tristate classifier.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sgtc_pkg::*;

   // One expected class-change event, in the order the rsp beats must arrive.
   typedef struct {
      square_type     square;
      class_type      old_class;
      class_type      new_class;
      event_kind_type kind;
   } grid_event_type;

   logic clock = 1'b0;
   logic reset;

   sgtc_req_if req_ch ();
   sgtc_rsp_if rsp_ch ();
   sgtc_csr_if csr_ch ();

   sensor_grid_tristate_classifier dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always #5ns clock = ~clock;

   // Shadow copy of the block's state, advanced at every accepted req beat.
   base_type       baseline_mem [SQUARES];
   class_type      class_mem    [SQUARES];
   sens_type       sens_reg;
   grid_event_type pending_events [$];

   int fail_count  = 0;
   bit tx_idle     = 1'b0;    // sender inserts random gaps between beats
   bit rx_idle     = 1'b0;    // receiver inserts random stalls between beats
   int hold_cycles = 0;       // one-shot long stall request for the receiver

   initial begin
      sens_reg = '0;
      foreach (baseline_mem[i]) begin
         baseline_mem[i] = '0;
         class_mem[i]    = CLASS_EMPTY;
      end
   end

   // Signed, exact compare against the dead band; no wraparound.
   function automatic class_type classify_sample(int reading, int base, int band);
      if (reading < base - band)
         return CLASS_BLACK;
      if (reading > base + band)
         return CLASS_WHITE;
      return CLASS_EMPTY;
   endfunction

   // Apply one accepted beat to the shadow state; queue an event on a class change.
   function automatic void track_beat(kind_type k, square_type sq, sample_in_type smp);
      class_type      fresh;
      class_type      prior;
      grid_event_type ev;
      if (int'(sq) >= SQUARES)
         return;
      if (k == KIND_CALIBRATE) begin
         baseline_mem[sq] = base_type'(smp);
         return;
      end
      fresh = classify_sample(int'(base_type'(smp)), int'(baseline_mem[sq]),
                              int'(sens_reg));
      prior = class_mem[sq];
      if (fresh == prior)
         return;
      ev.square    = sq;
      ev.old_class = prior;
      ev.new_class = fresh;
      if (prior == CLASS_EMPTY)
         ev.kind = EV_PLACED;
      else if (fresh == CLASS_EMPTY)
         ev.kind = EV_REMOVED;
      else
         ev.kind = EV_REPLACED;
      class_mem[sq] = fresh;
      pending_events.push_back(ev);
   endfunction

   // Offer one req beat after an optional gap; valid stays high on return so
   // back-to-back beats never drop it within the same step.
   task automatic send_beat(kind_type k, square_type sq, sample_in_type smp);
      int gap;
      gap = tx_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.kind   <= k;
      req_ch.square <= sq;
      req_ch.sample <= smp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      track_beat(k, sq, smp);
   endtask

   // Drop valid, wait out every expected event, then let the two-stage pipe
   // flush any trailing beat that emits nothing.
   task automatic settle_pipeline();
      req_ch.valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the sensitivity register; only called while the block is idle.
   task automatic write_sensitivity(sens_type band);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= band;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sens_reg = band;
      csr_ch.valid <= 1'b0;
   endtask

   // Walk every transition kind with zero dead band, field extremes included.
   task automatic test_class_transitions();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      send_beat(KIND_MEASURE,   6'd5,  10'd0);     // empty stays empty: no event
      send_beat(KIND_MEASURE,   6'd5,  10'd1023);  // placed white
      send_beat(KIND_MEASURE,   6'd5,  10'd1023);  // unchanged class: no event
      send_beat(KIND_CALIBRATE, 6'd5,  10'd1023);  // baseline only, class kept
      send_beat(KIND_MEASURE,   6'd5,  10'd0);     // replaced white by black
      send_beat(KIND_MEASURE,   6'd5,  10'd1023);  // on the baseline: removed
      send_beat(KIND_CALIBRATE, 6'd63, 10'h2AA);
      send_beat(KIND_MEASURE,   6'd63, 10'h2A9);   // placed black
      send_beat(KIND_MEASURE,   6'd63, 10'h2AB);   // replaced black by white
      send_beat(KIND_MEASURE,   6'd63, 10'h2AA);   // removed
      send_beat(KIND_CALIBRATE, 6'd0,  10'h155);
      send_beat(KIND_MEASURE,   6'd0,  10'h155);   // no event
      send_beat(KIND_MEASURE,   6'd42, 10'h3FF);   // placed white, baseline zero
      settle_pipeline();
   endtask

   // Probe the dead band at its widest and at a width of one.
   task automatic test_dead_band();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      write_sensitivity(10'd1023);
      send_beat(KIND_MEASURE,   6'd10, 10'd1023);  // inside the widest band
      send_beat(KIND_CALIBRATE, 6'd11, 10'd1023);
      send_beat(KIND_MEASURE,   6'd11, 10'd0);     // lower edge: still empty
      settle_pipeline();
      write_sensitivity(10'd1);
      send_beat(KIND_CALIBRATE, 6'd40, 10'd512);
      send_beat(KIND_MEASURE,   6'd40, 10'd510);   // just below the band
      send_beat(KIND_MEASURE,   6'd40, 10'd511);   // band edge: empty
      send_beat(KIND_MEASURE,   6'd40, 10'd513);   // band edge: no event
      send_beat(KIND_MEASURE,   6'd40, 10'd514);   // just above the band
      settle_pipeline();
   endtask

   // Stall the receiver for a long stretch while a dense event stream keeps
   // coming, so the held rsp register backs up into req.ready.
   task automatic test_backpressure();
      sample_in_type cycle_vals [3];
      cycle_vals[0] = 10'd0;
      cycle_vals[1] = 10'd1023;
      cycle_vals[2] = 10'd512;
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      write_sensitivity(10'd0);
      send_beat(KIND_CALIBRATE, 6'd20, 10'd512);
      hold_cycles = 150;
      for (int i = 0; i < 80; i++)
         send_beat(KIND_MEASURE, 6'd20, cycle_vals[i % 3]);
      settle_pipeline();
   endtask

   // One random phase: fixed sensitivity, mostly measures around a few
   // focus squares, with half of the samples near their baselines.
   task automatic run_random_phase(int count, sens_type band, bit tx_gaps, bit rx_gaps);
      int         focus;
      int         span;
      int         level;
      kind_type   k;
      square_type sq;
      write_sensitivity(band);
      tx_idle = tx_gaps;
      rx_idle = rx_gaps;
      focus   = $urandom_range(0, SQUARES - 4);
      span    = int'(band) + 4;
      for (int i = 0; i < count; i++) begin
         k  = ($urandom_range(0, 99) < 15) ? KIND_CALIBRATE : KIND_MEASURE;
         sq = ($urandom_range(0, 99) < 70) ? square_type'(focus + $urandom_range(0, 3))
                                           : square_type'($urandom_range(0, 63));
         if ($urandom_range(0, 1) == 0) begin
            level = $urandom_range(0, 1023);
         end else begin
            level = int'(baseline_mem[sq]) + int'($urandom_range(0, 2 * span)) - span;
            if (level < 0)
               level = 0;
            if (level > 1023)
               level = 1023;
         end
         send_beat(k, sq, sample_in_type'(level));
      end
      settle_pipeline();
   endtask

   task automatic test_random_traffic();
      run_random_phase(240, 10'd0,    1'b1, 1'b1);
      run_random_phase(240, 10'd1023, 1'b0, 1'b0);
      run_random_phase(240, 10'd1,    1'b1, 1'b0);
      run_random_phase(240, sens_type'($urandom_range(0, 1023)), 1'b0, 1'b1);
      run_random_phase(240, sens_type'($urandom_range(0, 15)),   1'b1, 1'b1);
      run_random_phase(240, sens_type'($urandom_range(0, 63)),   1'b0, 1'b0);
   endtask

   // Receiver: when rx_idle is set, stall a random number of cycles per beat, plus any
   // requested long hold, then keep ready high until a beat lands or a hold is requested.
   initial begin : rsp_sink
      int off;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         off = (rx_idle ? $urandom_range(0, 19) : 0) + hold_cycles;
         hold_cycles = 0;
         if (off > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (off) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid && hold_cycles == 0) @(posedge clock);
      end
   end

   // Compare every accepted event beat against the oldest expectation.
   always @(posedge clock) begin : event_check
      grid_event_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_events.size() == 0) begin
            $error("unexpected event beat: square %0d old %0d new %0d kind %0d",
                   rsp_ch.event_square, rsp_ch.old_class, rsp_ch.new_class,
                   rsp_ch.event_kind);
            fail_count++;
         end else begin
            want = pending_events.pop_front();
            if (rsp_ch.event_square !== want.square) begin
               $error("event_square: expected %0d, actual %0d",
                      want.square, rsp_ch.event_square);
               fail_count++;
            end
            if (rsp_ch.old_class !== want.old_class) begin
               $error("old_class: expected %0d, actual %0d",
                      want.old_class, rsp_ch.old_class);
               fail_count++;
            end
            if (rsp_ch.new_class !== want.new_class) begin
               $error("new_class: expected %0d, actual %0d",
                      want.new_class, rsp_ch.new_class);
               fail_count++;
            end
            if (rsp_ch.event_kind !== want.kind) begin
               $error("event_kind: expected %0d, actual %0d",
                      want.kind, rsp_ch.event_kind);
               fail_count++;
            end
         end
      end
   end

   // Main sequence: hold reset, run each test in turn, then report.
   initial begin
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.kind   <= KIND_CALIBRATE;
      req_ch.square <= '0;
      req_ch.sample <= '0;
      csr_ch.valid  <= 1'b0;
      csr_ch.data   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The clearing pass after reset holds req.ready low; send_beat waits it out.
      test_class_transitions();
      test_dead_band();
      test_backpressure();
      test_random_traffic();

      // Drain any leftovers and give the pipe a few cycles to show stray beats.
      while (pending_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog: well beyond the slowest legal run.
   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
